// ===== sv/bpr_pkg.sv =====
// Package for the binned polynomial resolution block: widths, types, bins and arithmetic helpers.
package bpr_pkg;

  // Coefficient storage and polynomial shape
  localparam int COEF_W      = 48;
  localparam int POLY_TERMS  = 6;
  localparam int NUM_PT_BINS = 6;
  localparam int NUM_REGIONS = 3;
  localparam int TABLE_DEPTH = NUM_REGIONS * NUM_PT_BINS * POLY_TERMS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int POW_W       = $clog2(POLY_TERMS);

  // Fixed field widths of the request and result
  localparam int SLOT_W  = 7;
  localparam int VALUE_W = 48;
  localparam int ETA_W   = 16;
  localparam int PT_W    = 14;
  localparam int OUT_W   = 48;

  // Multiplier split and rounding
  localparam int ETA_FRAC = 14;
  localparam int LO_W     = COEF_W / 2;
  localparam int HI_W     = COEF_W - LO_W;
  localparam int FULL_W   = COEF_W + ETA_W + 1;
  localparam int RND_W    = FULL_W - ETA_FRAC;

  // Eta window edges in Q2.14
  localparam logic [ETA_W-1:0] ETA_1P18 = 16'd19333;
  localparam logic [ETA_W-1:0] ETA_1P22 = 16'd19988;
  localparam logic [ETA_W-1:0] ETA_1P24 = 16'd20316;
  localparam logic [ETA_W-1:0] ETA_2P22 = 16'd36372;
  localparam logic [ETA_W-1:0] ETA_2P24 = 16'd36700;
  localparam logic [ETA_W-1:0] ETA_2P80 = 16'd45875;

  // Pt bin edges in 1/64 GeV
  localparam logic [PT_W-1:0] PT_EDGES [NUM_PT_BINS+1] =
    '{14'd64, 14'd96, 14'd160, 14'd320, 14'd640, 14'd1280, 14'd6400};

  localparam logic [1:0] REGION_BARREL = 2'd0;
  localparam logic [1:0] REGION_MID    = 2'd1;
  localparam logic [1:0] REGION_FWD    = 2'd2;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic        [COEF_W-1:0]  mag_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [OUT_W-1:0]   res_t;
  typedef logic        [ADDR_W-1:0]  addr_t;

  localparam coef_t CW_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t CW_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam longint CW_MAX64  = longint'(CW_MAX);
  localparam longint CW_MIN64  = longint'(CW_MIN);
  localparam longint OUT_MAX64 = longint'({1'b0, {(OUT_W-1){1'b1}}});
  localparam longint OUT_MIN64 = -OUT_MAX64 - 64'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_INIT,
    ST_MAG,
    ST_MUL,
    ST_RND,
    ST_SGN,
    ST_ADD
  } state_t;

  // Which windows an evaluate request falls into
  typedef struct packed {
    logic       hit;
    logic       two;
    logic [1:0] first;
    logic [1:0] second;
    logic [2:0] bin;
  } window_t;

  function automatic window_t decode(logic [ETA_W-1:0] eta, logic [PT_W-1:0] pt);
    window_t          w;
    logic             bin_hit;
    logic [2:0]       bin;
    logic [ETA_W-1:0] hi0;
    logic [ETA_W-1:0] lo1;
    logic             in0;
    logic             in1;
    logic             in2;
    bin_hit = 1'b0;
    bin     = '0;
    for (int b = 0; b < NUM_PT_BINS; b++) begin
      if (pt >= PT_EDGES[b] && pt < PT_EDGES[b+1]) begin
        bin_hit = 1'b1;
        bin     = 3'(b);
      end
    end
    hi0 = (bin < 3'd3) ? ETA_1P22 : ETA_1P24;
    lo1 = (bin < 3'd3) ? ETA_1P18 : ETA_1P22;
    in0 = eta < hi0;
    in1 = eta >= lo1 && eta < ETA_2P24;
    in2 = eta >= ETA_2P22 && eta < ETA_2P80;
    w.bin    = bin;
    w.hit    = bin_hit && (in0 || in1 || in2);
    w.two    = (in0 && in1) || (in1 && in2);
    w.first  = in0 ? REGION_BARREL : (in1 ? REGION_MID : REGION_FWD);
    w.second = in0 ? REGION_MID : REGION_FWD;
    return w;
  endfunction

  function automatic addr_t slot_addr(logic [1:0] region, logic [2:0] bin,
                                      logic [POW_W-1:0] power);
    int a;
    a = (int'(region) * NUM_PT_BINS + int'(bin)) * POLY_TERMS + int'(power);
    return ADDR_W'(a);
  endfunction

  // Clamp a loaded value to the coefficient range
  function automatic coef_t sat_in(value_t v);
    longint x;
    x = longint'(v);
    if (x > CW_MAX64) begin
      return CW_MAX;
    end
    if (x < CW_MIN64) begin
      return CW_MIN;
    end
    return COEF_W'(x);
  endfunction

  // Clamp a coefficient-width value to the result range
  function automatic res_t sat_out(coef_t v);
    longint x;
    x = longint'(v);
    if (x > OUT_MAX64) begin
      return OUT_W'(OUT_MAX64);
    end
    if (x < OUT_MIN64) begin
      return OUT_W'(OUT_MIN64);
    end
    return OUT_W'(x);
  endfunction

  function automatic coef_t sat_add(coef_t a, coef_t b);
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return s[COEF_W] ? CW_MIN : CW_MAX;
    end
    return s[COEF_W-1:0];
  endfunction

endpackage

// ===== sv/bpr_in_if.sv =====
// Request channel: load or evaluate command with its fields.
interface bpr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [bpr_pkg::SLOT_W-1:0]    coef_slot;
  logic signed [bpr_pkg::VALUE_W-1:0] coef_value;
  logic [bpr_pkg::ETA_W-1:0]     eta;
  logic [bpr_pkg::PT_W-1:0]      pt;

  modport source (output valid, command, coef_slot, coef_value, eta, pt, input ready);
  modport sink   (input valid, command, coef_slot, coef_value, eta, pt, output ready);
endinterface

// ===== sv/bpr_out_if.sv =====
// Result channel: evaluated resolution and range flag.
interface bpr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bpr_pkg::OUT_W-1:0] resolution;
  logic                             in_range;

  modport source (output valid, resolution, in_range, input ready);
  modport sink   (input valid, resolution, in_range, output ready);
endinterface

// ===== sv/binned_polynomial_resolution_top.sv =====
// Top level: coefficient memory and sequenced Horner evaluation of binned resolution.
//
// A load request writes one coefficient into a 108-entry synchronous memory
// while the sequencer stays in idle. An evaluate request picks the pt bin and
// the eta windows, then runs Horner's rule over the memory through one shared
// multiply-add: each power passes through magnitude, 24x16 partial products,
// round, sign and clamp, and add and clamp, and each polynomial first reads its
// top coefficient in the fetch and init states; an overlap of two windows runs
// both polynomials in turn and averages them. A point outside every window goes
// straight to the add state. The memory read port and the single multiply-add
// set this sequence. The next request is taken as soon as the sequencer is back
// in idle, even while the last result still waits in the output register. The
// memory has no reset; every entry must be loaded before it is used.
module binned_polynomial_resolution_top (
  input  logic       clk,
  input  logic       rst,
  bpr_in_if.sink     track,
  bpr_out_if.source  result
);

  localparam logic [bpr_pkg::POW_W-1:0] TOP_POWER = bpr_pkg::POW_W'(bpr_pkg::POLY_TERMS - 1);
  localparam logic [bpr_pkg::POW_W-1:0] POW_ONE   = bpr_pkg::POW_W'(1);
  localparam logic [bpr_pkg::FULL_W-1:0] HALF_LSB =
    bpr_pkg::FULL_W'(1) << (bpr_pkg::ETA_FRAC - 1);

  bpr_pkg::state_t  state;
  bpr_pkg::state_t  state_next;

  // Coefficient memory
  bpr_pkg::coef_t   coef_mem [bpr_pkg::TABLE_DEPTH];
  bpr_pkg::coef_t   rd_data;
  logic             rd_en;
  bpr_pkg::addr_t   rd_addr;
  logic             load_en;

  // Sequencer context
  bpr_pkg::window_t win;
  logic             ok;
  logic             two;
  logic             lane;
  logic [1:0]       region;
  logic [1:0]       region_second;
  logic [2:0]       bin;
  logic [bpr_pkg::POW_W-1:0] power;
  logic [bpr_pkg::ETA_W-1:0] eta;

  // Multiply-add datapath
  bpr_pkg::coef_t   acc;
  bpr_pkg::coef_t   acc_next;
  bpr_pkg::coef_t   first_res;
  bpr_pkg::mag_t    mag;
  logic             neg;
  logic [bpr_pkg::LO_W+bpr_pkg::ETA_W-1:0] prod_lo;
  logic [bpr_pkg::HI_W+bpr_pkg::ETA_W-1:0] prod_hi;
  logic [bpr_pkg::FULL_W-1:0] full;
  logic [bpr_pkg::RND_W-1:0]  rnd;
  bpr_pkg::coef_t   prod;

  // Result path
  logic signed [bpr_pkg::COEF_W:0] pair_sum;
  bpr_pkg::coef_t   avg;
  logic             post;
  logic             poly_done;
  logic             eval_req;

  assign eval_req  = track.valid && track.ready && track.command;
  assign load_en   = track.valid && track.ready && !track.command &&
                     (int'(track.coef_slot) < bpr_pkg::TABLE_DEPTH);
  assign win       = bpr_pkg::decode(track.eta, track.pt);
  assign acc_next  = bpr_pkg::sat_add(prod, rd_data);
  assign poly_done = (power == '0);
  assign full      = (bpr_pkg::FULL_W'(prod_hi) << bpr_pkg::LO_W) +
                     bpr_pkg::FULL_W'(prod_lo) + HALF_LSB;
  // Average the last window's final add with the first window, or pass it through
  assign pair_sum  = two ? ({first_res[bpr_pkg::COEF_W-1], first_res} +
                            {acc_next[bpr_pkg::COEF_W-1], acc_next})
                         : ({acc_next[bpr_pkg::COEF_W-1], acc_next} +
                            {acc_next[bpr_pkg::COEF_W-1], acc_next});
  assign avg       = pair_sum[bpr_pkg::COEF_W:1];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpr_pkg::ST_IDLE: begin
        if (eval_req) begin
          state_next = win.hit ? bpr_pkg::ST_FETCH : bpr_pkg::ST_ADD;
        end
      end
      bpr_pkg::ST_FETCH: state_next = bpr_pkg::ST_INIT;
      bpr_pkg::ST_INIT:  state_next = bpr_pkg::ST_MAG;
      bpr_pkg::ST_MAG:   state_next = bpr_pkg::ST_MUL;
      bpr_pkg::ST_MUL:   state_next = bpr_pkg::ST_RND;
      bpr_pkg::ST_RND:   state_next = bpr_pkg::ST_SGN;
      bpr_pkg::ST_SGN:   state_next = bpr_pkg::ST_ADD;
      bpr_pkg::ST_ADD: begin
        priority if (!ok || (lane == two && poly_done)) begin
          if (!result.valid || result.ready) begin
            state_next = bpr_pkg::ST_IDLE;
          end
        end else if (poly_done) begin
          state_next = bpr_pkg::ST_FETCH;
        end else begin
          state_next = bpr_pkg::ST_MAG;
        end
      end
      default: state_next = bpr_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    track.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = bpr_pkg::slot_addr(region, bin, power);
    post        = 1'b0;
    unique case (state)
      bpr_pkg::ST_IDLE:  track.ready = 1'b1;
      bpr_pkg::ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = bpr_pkg::slot_addr(region, bin, TOP_POWER);
      end
      bpr_pkg::ST_MAG:   rd_en = 1'b1;
      bpr_pkg::ST_ADD: begin
        post = (!ok || (lane == two && poly_done)) && (!result.valid || result.ready);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (load_en) begin
      coef_mem[bpr_pkg::ADDR_W'(track.coef_slot)] <= bpr_pkg::sat_in(track.coef_value);
    end
    if (rd_en) begin
      rd_data <= coef_mem[rd_addr];
    end
  end

  // Sequencer context and multiply-add stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ok   <= 1'b0;
      two  <= 1'b0;
      lane <= 1'b0;
    end else begin
      unique case (state)
        bpr_pkg::ST_IDLE: begin
          if (eval_req) begin
            ok            <= win.hit;
            two           <= win.two;
            lane          <= 1'b0;
            region        <= win.first;
            region_second <= win.second;
            bin           <= win.bin;
            eta           <= track.eta;
          end
        end
        bpr_pkg::ST_INIT: begin
          acc   <= rd_data;
          power <= TOP_POWER - POW_ONE;
        end
        bpr_pkg::ST_MAG: begin
          neg <= acc[bpr_pkg::COEF_W-1];
          mag <= acc[bpr_pkg::COEF_W-1] ? bpr_pkg::mag_t'(-acc) : bpr_pkg::mag_t'(acc);
        end
        bpr_pkg::ST_MUL: begin
          prod_lo <= mag[bpr_pkg::LO_W-1:0] * eta;
          prod_hi <= mag[bpr_pkg::COEF_W-1:bpr_pkg::LO_W] * eta;
        end
        bpr_pkg::ST_RND: rnd <= full[bpr_pkg::FULL_W-1:bpr_pkg::ETA_FRAC];
        bpr_pkg::ST_SGN: begin
          // clamp the rounded magnitude, then restore the sign
          if (rnd[bpr_pkg::RND_W-1:bpr_pkg::COEF_W-1] != '0) begin
            prod <= neg ? bpr_pkg::CW_MIN : bpr_pkg::CW_MAX;
          end else begin
            prod <= neg ? bpr_pkg::coef_t'(-rnd[bpr_pkg::COEF_W-1:0])
                        : bpr_pkg::coef_t'(rnd[bpr_pkg::COEF_W-1:0]);
          end
        end
        bpr_pkg::ST_ADD: begin
          if (ok && !(lane == two && poly_done)) begin
            acc <= acc_next;
            if (poly_done) begin
              // first window finished: keep it and move to the second
              first_res <= acc_next;
              lane      <= 1'b1;
              region    <= region_second;
            end else begin
              power <= power - POW_ONE;
            end
          end else if (ok) begin
            acc <= acc_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (post) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      result.in_range   <= ok;
      result.resolution <= ok ? bpr_pkg::sat_out(avg) : '0;
    end
  end

  // Hold a stalled result unchanged
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=>
      result.valid && $stable(result.resolution) && $stable(result.in_range));

  // An out-of-range result carries zero
  a_zero_out_of_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.in_range |-> result.resolution == '0);

  // Take requests only in idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    track.ready |-> state == bpr_pkg::ST_IDLE);

  // Post only into a free output register
  a_post_free: assert property (@(posedge clk) disable iff (rst)
    post |-> !result.valid || result.ready);

endmodule

// ===== dv/tb_binned_polynomial_resolution_top.sv =====
// Testbench for binned_polynomial_resolution_top: coefficient loads and resolution checks.
module tb_binned_polynomial_resolution_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PROD_W       = bpr_pkg::COEF_W + bpr_pkg::ETA_W + 1;
  localparam logic [PROD_W-1:0] ACC_TOP = PROD_W'(bpr_pkg::CW_MAX64);
  localparam int ETA_EDGE [6] = '{19333, 19988, 20316, 36372, 36700, 45875};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef struct {
    cmd_e                       command;
    logic [bpr_pkg::SLOT_W-1:0] slot;
    bpr_pkg::value_t            value;
    logic [bpr_pkg::ETA_W-1:0]  eta;
    logic [bpr_pkg::PT_W-1:0]   pt;
  } track_req_t;

  typedef struct packed {
    bpr_pkg::res_t resolution;
    logic          in_range;
  } resol_t;

  logic clk = 1'b0;
  logic rst;

  bpr_in_if  track_if ();
  bpr_out_if result_if ();

  binned_polynomial_resolution_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .track  (track_if),
    .result (result_if)
  );

  always #2 clk = ~clk;

  // Predictor state and bookkeeping
  bpr_pkg::coef_t coef_mem [bpr_pkg::TABLE_DEPTH];
  resol_t     expected_q [$];
  track_req_t req_q [$];
  track_req_t next_req;
  logic       req_taken;
  int         queued_cnt;
  int         taken_cnt;
  int         err_cnt;
  int         cycle_cnt;
  int         src_idle_pct;
  int         sink_idle_pct;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // round(acc * eta / 2^14), half away from zero, clamped to the coefficient range
  function automatic bpr_pkg::coef_t scale_by_eta(bpr_pkg::coef_t acc,
                                                  logic [bpr_pkg::ETA_W-1:0] eta);
    logic [bpr_pkg::COEF_W-1:0] mag;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quo;
    mag  = acc[bpr_pkg::COEF_W-1] ? bpr_pkg::COEF_W'(-acc) : bpr_pkg::COEF_W'(acc);
    prod = PROD_W'(mag) * PROD_W'(eta) + PROD_W'(1 << (bpr_pkg::ETA_FRAC - 1));
    quo  = prod >> bpr_pkg::ETA_FRAC;
    if (quo > ACC_TOP) begin
      return acc[bpr_pkg::COEF_W-1] ? bpr_pkg::CW_MIN : bpr_pkg::CW_MAX;
    end
    return acc[bpr_pkg::COEF_W-1] ? -bpr_pkg::coef_t'(quo[bpr_pkg::COEF_W-1:0])
                                  : bpr_pkg::coef_t'(quo[bpr_pkg::COEF_W-1:0]);
  endfunction

  function automatic bpr_pkg::coef_t add_clamped(bpr_pkg::coef_t a, bpr_pkg::coef_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > bpr_pkg::CW_MAX64) begin
      return bpr_pkg::CW_MAX;
    end
    if (s < bpr_pkg::CW_MIN64) begin
      return bpr_pkg::CW_MIN;
    end
    return bpr_pkg::coef_t'(s);
  endfunction

  function automatic bpr_pkg::coef_t mean_floor(bpr_pkg::coef_t a, bpr_pkg::coef_t b);
    longint s;
    s = longint'(a) + longint'(b);
    return bpr_pkg::coef_t'(s >>> 1);
  endfunction

  // Horner's rule over one region and pt bin
  function automatic bpr_pkg::coef_t poly_at(int region, int bin,
                                             logic [bpr_pkg::ETA_W-1:0] eta);
    int             base;
    bpr_pkg::coef_t acc;
    base = (region * bpr_pkg::NUM_PT_BINS + bin) * bpr_pkg::POLY_TERMS;
    acc  = coef_mem[base + bpr_pkg::POLY_TERMS - 1];
    for (int k = bpr_pkg::POLY_TERMS - 2; k >= 0; k--) begin
      acc = add_clamped(scale_by_eta(acc, eta), coef_mem[base + k]);
    end
    return acc;
  endfunction

  function automatic resol_t predict_resolution(logic [bpr_pkg::ETA_W-1:0] eta,
                                                logic [bpr_pkg::PT_W-1:0] pt);
    resol_t                    r;
    int                        bin;
    logic [bpr_pkg::ETA_W-1:0] top0;
    logic [bpr_pkg::ETA_W-1:0] base1;
    logic                      in0;
    logic                      in1;
    logic                      in2;
    r.resolution = '0;
    r.in_range   = 1'b0;
    bin          = -1;
    for (int k = 0; k < bpr_pkg::NUM_PT_BINS; k++) begin
      if (pt >= bpr_pkg::PT_EDGES[k] && pt < bpr_pkg::PT_EDGES[k+1]) begin
        bin = k;
      end
    end
    if (bin < 0) begin
      return r;
    end
    top0  = (bin < 3) ? bpr_pkg::ETA_1P22 : bpr_pkg::ETA_1P24;
    base1 = (bin < 3) ? bpr_pkg::ETA_1P18 : bpr_pkg::ETA_1P22;
    in0   = eta < top0;
    in1   = eta >= base1 && eta < bpr_pkg::ETA_2P24;
    in2   = eta >= bpr_pkg::ETA_2P22 && eta < bpr_pkg::ETA_2P80;
    if (in0 && in1) begin
      r.resolution = mean_floor(poly_at(0, bin, eta), poly_at(1, bin, eta));
    end else if (in1 && in2) begin
      r.resolution = mean_floor(poly_at(1, bin, eta), poly_at(2, bin, eta));
    end else if (in0) begin
      r.resolution = poly_at(0, bin, eta);
    end else if (in1) begin
      r.resolution = poly_at(1, bin, eta);
    end else if (in2) begin
      r.resolution = poly_at(2, bin, eta);
    end
    r.in_range = in0 || in1 || in2;
    return r;
  endfunction

  function automatic void store_coef(logic [bpr_pkg::SLOT_W-1:0] slot,
                                     bpr_pkg::value_t value);
    if (slot < bpr_pkg::TABLE_DEPTH) begin
      coef_mem[slot] = value;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver, result ready, monitor and watchdog
  // ---------------------------------------------------------------------------

  // Present the next queued request once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      track_if.valid <= 1'b0;
    end else if (!track_if.valid || req_taken) begin
      if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_req             = req_q.pop_front();
        track_if.command    <= next_req.command;
        track_if.coef_slot  <= next_req.slot;
        track_if.coef_value <= next_req.value;
        track_if.eta        <= next_req.eta;
        track_if.pt         <= next_req.pt;
        track_if.valid      <= 1'b1;
      end else begin
        track_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    result_if.ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  // Check each result against the oldest expectation, then predict new requests
  always @(posedge clk) begin : monitor
    resol_t want;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, actual resolution %0d in_range %0b",
                   $time, result_if.resolution, result_if.in_range);
        end else begin
          want = expected_q.pop_front();
          if (result_if.resolution !== want.resolution) begin
            err_cnt++;
            $display("%0t: resolution mismatch: expected %0d, actual %0d",
                     $time, want.resolution, result_if.resolution);
          end
          if (result_if.in_range !== want.in_range) begin
            err_cnt++;
            $display("%0t: in_range mismatch: expected %0b, actual %0b",
                     $time, want.in_range, result_if.in_range);
          end
        end
      end
      if (track_if.valid && track_if.ready) begin
        taken_cnt <= taken_cnt + 1;
        if (track_if.command == CMD_EVAL) begin
          expected_q.push_back(predict_resolution(track_if.eta, track_if.pt));
        end else begin
          store_coef(track_if.coef_slot, track_if.coef_value);
        end
      end
    end
    req_taken <= !rst && track_if.valid && track_if.ready;
  end

  // End the run if the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request helpers
  // ---------------------------------------------------------------------------

  // Queue one request and hold until the block takes it
  task automatic send_request(input track_req_t r);
    int ticket;
    req_q.push_back(r);
    queued_cnt++;
    ticket = queued_cnt;
    wait (taken_cnt >= ticket);
  endtask

  task automatic load_coef(input logic [bpr_pkg::SLOT_W-1:0] slot,
                           input bpr_pkg::value_t value);
    track_req_t r;
    r.command = CMD_LOAD;
    r.slot    = slot;
    r.value   = value;
    r.eta     = bpr_pkg::ETA_W'($urandom_range(0, 65535));
    r.pt      = bpr_pkg::PT_W'($urandom_range(0, 16383));
    send_request(r);
  endtask

  task automatic eval_track(input logic [bpr_pkg::ETA_W-1:0] eta,
                            input logic [bpr_pkg::PT_W-1:0] pt);
    track_req_t r;
    r.command = CMD_EVAL;
    r.slot    = bpr_pkg::SLOT_W'($urandom_range(0, 127));
    r.value   = bpr_pkg::value_t'({$urandom(), $urandom()});
    r.eta     = eta;
    r.pt      = pt;
    send_request(r);
  endtask

  // Hold until every request is taken and every result has come back
  task automatic wait_results_in();
    while (taken_cnt != queued_cnt || expected_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic bpr_pkg::value_t random_coef();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return bpr_pkg::value_t'(longint'(int'($urandom())) >>> 1);
      6, 7:             return bpr_pkg::value_t'({$urandom(), $urandom()});
      8:                return bpr_pkg::value_t'(bpr_pkg::CW_MAX);
      default:          return bpr_pkg::value_t'(bpr_pkg::CW_MIN);
    endcase
  endfunction

  function automatic logic [bpr_pkg::ETA_W-1:0] random_eta();
    int e;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        e = ETA_EDGE[$urandom_range(5)] + int'($urandom_range(0, 8)) - 4;
        return bpr_pkg::ETA_W'(e);
      end
      5, 6, 7: return bpr_pkg::ETA_W'($urandom_range(0, 45874));
      default: return bpr_pkg::ETA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [bpr_pkg::PT_W-1:0] random_pt();
    int b;
    b = $urandom_range(bpr_pkg::NUM_PT_BINS - 1);
    case ($urandom_range(9))
      8:       return bpr_pkg::PT_W'($urandom_range(0, 63));
      9:       return bpr_pkg::PT_W'($urandom_range(0, 16383));
      default: return bpr_pkg::PT_W'($urandom_range(int'(bpr_pkg::PT_EDGES[b]),
                                                    int'(bpr_pkg::PT_EDGES[b+1]) - 1));
    endcase
  endfunction

  // Mostly evaluates over the fitted windows, some loads, a few ignored slots
  task automatic random_request();
    if ($urandom_range(99) < 25) begin
      if ($urandom_range(9) == 0) begin
        load_coef(bpr_pkg::SLOT_W'($urandom_range(bpr_pkg::TABLE_DEPTH, 127)), random_coef());
      end else begin
        load_coef(bpr_pkg::SLOT_W'($urandom_range(0, bpr_pkg::TABLE_DEPTH - 1)),
                  random_coef());
      end
    end else begin
      eval_track(random_eta(), random_pt());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every slot before any evaluate; also poke slots past the table
  task automatic test_table_load();
    for (int s = 0; s < bpr_pkg::TABLE_DEPTH; s++) begin
      load_coef(bpr_pkg::SLOT_W'(s), bpr_pkg::value_t'(longint'(int'($urandom())) >>> 2));
    end
    load_coef(bpr_pkg::SLOT_W'(bpr_pkg::TABLE_DEPTH), bpr_pkg::value_t'(bpr_pkg::CW_MAX));
    load_coef(bpr_pkg::SLOT_W'(127), bpr_pkg::value_t'(bpr_pkg::CW_MIN));
  endtask

  // Eta window edges for low and high pt bins, pt bin edges, eta extremes
  task automatic test_window_edges();
    logic [bpr_pkg::ETA_W-1:0] low_bin_eta [10];
    logic [bpr_pkg::ETA_W-1:0] high_bin_eta [4];
    logic [bpr_pkg::PT_W-1:0]  edge_pt [8];
    low_bin_eta  = '{19332, 19333, 19987, 19988, 36371, 36372, 36699, 36700,
                     45874, 45875};
    high_bin_eta = '{19987, 19988, 20315, 20316};
    edge_pt      = '{0, 63, 64, 96, 1280, 6399, 6400, 16383};
    foreach (low_bin_eta[i]) begin
      eval_track(low_bin_eta[i], bpr_pkg::PT_W'(200));
    end
    foreach (high_bin_eta[i]) begin
      eval_track(high_bin_eta[i], bpr_pkg::PT_W'(400));
    end
    foreach (edge_pt[i]) begin
      eval_track(bpr_pkg::ETA_W'(10000), edge_pt[i]);
    end
    eval_track(bpr_pkg::ETA_W'(0), bpr_pkg::PT_W'(64));
    eval_track(bpr_pkg::ETA_W'(65535), bpr_pkg::PT_W'(6399));
  endtask

  // Extreme coefficients: clamp in the multiply and in the add, and average extreme windows
  task automatic test_saturation();
    for (int p = 0; p < bpr_pkg::POLY_TERMS; p++) begin
      load_coef(bpr_pkg::SLOT_W'(p), bpr_pkg::value_t'(bpr_pkg::CW_MAX));
    end
    eval_track(bpr_pkg::ETA_W'(19000), bpr_pkg::PT_W'(64));
    eval_track(bpr_pkg::ETA_W'(0), bpr_pkg::PT_W'(64));
    for (int p = 0; p < bpr_pkg::POLY_TERMS; p++) begin
      load_coef(bpr_pkg::SLOT_W'(bpr_pkg::NUM_PT_BINS * bpr_pkg::POLY_TERMS + p),
                bpr_pkg::value_t'(bpr_pkg::CW_MIN));
    end
    eval_track(bpr_pkg::ETA_W'(19500), bpr_pkg::PT_W'(64));
    eval_track(bpr_pkg::ETA_W'(25000), bpr_pkg::PT_W'(64));
    for (int p = 0; p < bpr_pkg::POLY_TERMS; p++) begin
      load_coef(bpr_pkg::SLOT_W'(2 * bpr_pkg::NUM_PT_BINS * bpr_pkg::POLY_TERMS + p),
                (p % 2 == 0) ? bpr_pkg::value_t'(bpr_pkg::CW_MAX)
                             : bpr_pkg::value_t'(bpr_pkg::CW_MIN));
    end
    eval_track(bpr_pkg::ETA_W'(36500), bpr_pkg::PT_W'(64));
    eval_track(bpr_pkg::ETA_W'(40000), bpr_pkg::PT_W'(64));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      random_request();
    end
  endtask

  // Drop all idling on both sides for a long stretch
  task automatic test_no_idle_stretch(input int count);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(count);
    src_idle_pct  = 10;
    sink_idle_pct = 10;
  endtask

  // Let the block run empty, then resume traffic
  task automatic test_pause_then_resume(input int count);
    wait_results_in();
    test_random_traffic(count);
  endtask

  initial begin
    rst                  = 1'b1;
    track_if.valid       = 1'b0;
    track_if.command     = CMD_LOAD;
    track_if.coef_slot   = '0;
    track_if.coef_value  = '0;
    track_if.eta         = '0;
    track_if.pt          = '0;
    result_if.ready      = 1'b0;
    req_taken            = 1'b0;
    queued_cnt           = 0;
    taken_cnt            = 0;
    err_cnt              = 0;
    cycle_cnt            = 0;
    src_idle_pct         = 10;
    sink_idle_pct        = 10;
    foreach (coef_mem[i]) begin
      coef_mem[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_load();
    test_window_edges();
    test_saturation();
    test_random_traffic(140);
    test_no_idle_stretch(70);
    test_pause_then_resume(32);

    // Drain and let any last result settle
    wait_results_in();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, expected_q.size());
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
